// ===== hdl/packet_command_table_matcher_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the command table matcher.
// ----------------------------------------------------------------------------
`ifndef PACKET_COMMAND_TABLE_MATCHER_TOP_ASSERT_SVH
`define PACKET_COMMAND_TABLE_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define PCTM_ASSERT_SAME(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define PCTM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// ===== hdl/pctm_pkg.sv =====
// ----------------------------------------------------------------------------
// pctm_pkg
// Types, codes and default sizes for the packet command table matcher.
// ----------------------------------------------------------------------------
package pctm_pkg;

    localparam int ENTRIES_DEF           = 64;
    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int MAX_PACKET_BYTES_DEF  = 64;
    localparam int NAME_BYTES_DEF        = 8;

    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int POS_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int NAME_W   = 64;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int ACTION_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PACKET       = 2'd0,
        OP_PATTERN_BYTE = 2'd1,
        OP_PATTERN_LEN  = 2'd2,
        OP_TYPE_NAME    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCHED  = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_REFUSED  = 2'd2
    } status_t;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VIDEO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCENE = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_VIDEO = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SCENE = 2'd2;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic end_pkt;
        logic done;
    } dp_stat_t;

endpackage

// ===== hdl/pctm_in_if.sv =====
// ----------------------------------------------------------------------------
// pctm_in_if
// Input word channel: load items and packet bytes.
// ----------------------------------------------------------------------------
interface pctm_in_if;
    import pctm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [POS_W-1:0]    byte_position;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    entry_length;
    logic [NAME_W-1:0]   type_name;
    logic                last_byte;

    modport source (
        output valid, opcode, entry_index, byte_position, data_byte,
               entry_length, type_name, last_byte,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, byte_position, data_byte,
               entry_length, type_name, last_byte,
        output ready
    );
endinterface

// ===== hdl/pctm_out_if.sv =====
// ----------------------------------------------------------------------------
// pctm_out_if
// Result word channel: match status, index, action and name.
// ----------------------------------------------------------------------------
interface pctm_out_if;
    import pctm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  matched_index;
    logic [ACTION_W-1:0] action;
    logic [NAME_W-1:0]   matched_name;

    modport source (
        output valid, status, matched_index, action, matched_name,
        input  ready
    );

    modport sink (
        input  valid, status, matched_index, action, matched_name,
        output ready
    );
endinterface

// ===== hdl/pctm_datapath.sv =====
// ----------------------------------------------------------------------------
// pctm_datapath
// Pattern table, packet buffer, sequential entry scan and result register.
// ----------------------------------------------------------------------------
module pctm_datapath #(
    parameter int ENTRIES           = pctm_pkg::ENTRIES_DEF,
    parameter int MAX_PATTERN_BYTES = pctm_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int MAX_PACKET_BYTES  = pctm_pkg::MAX_PACKET_BYTES_DEF,
    parameter int NAME_BYTES        = pctm_pkg::NAME_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pctm_pkg::ctrl_cmd_t           cmd,
    output pctm_pkg::dp_stat_t            stat,
    input  logic [pctm_pkg::OPCODE_W-1:0] opcode,
    input  logic [pctm_pkg::INDEX_W-1:0]  entry_index,
    input  logic [pctm_pkg::POS_W-1:0]    byte_position,
    input  logic [pctm_pkg::BYTE_W-1:0]   data_byte,
    input  logic [pctm_pkg::LEN_W-1:0]    entry_length,
    input  logic [pctm_pkg::NAME_W-1:0]   type_name,
    input  logic                          last_byte,
    input  logic                          cfg_we,
    input  logic [pctm_pkg::MODE_W-1:0]   cfg_wdata,
    output logic [pctm_pkg::STATUS_W-1:0] status,
    output logic [pctm_pkg::INDEX_W-1:0]  matched_index,
    output logic [pctm_pkg::ACTION_W-1:0] action,
    output logic [pctm_pkg::NAME_W-1:0]   matched_name
);
    import pctm_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CW = $clog2(MAX_PACKET_BYTES + 2);
    localparam int RW = BYTE_W * MAX_PATTERN_BYTES;
    localparam logic [NAME_W-1:0] NAME_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    logic [RW-1:0]     row_mem  [ENTRIES];
    logic [LW-1:0]     len_mem  [ENTRIES];
    logic [NAME_W-1:0] name_mem [ENTRIES];

    logic [ENTRIES-1:0] row_vld_reg;
    logic [ENTRIES-1:0] len_vld_reg;
    logic [ENTRIES-1:0] name_vld_reg;

    logic [BYTE_W-1:0] pkt_buf_reg [MAX_PATTERN_BYTES];

    logic [MODE_W-1:0] mode_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     pkt_len_reg;
    logic              refuse_reg;
    logic [AW-1:0]     addr_reg;
    logic              issue_on_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              rd_row_vld_reg;
    logic              rd_len_vld_reg;
    logic              rd_name_vld_reg;
    logic [RW-1:0]     rd_row_raw_reg;
    logic [LW-1:0]     rd_len_raw_reg;
    logic [NAME_W-1:0] rd_name_raw_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [NAME_W-1:0]   name_reg;

    opcode_t           op;
    logic [AW-1:0]     wr_addr;
    logic              entry_ok;
    logic              pos_ok;
    logic              row_we;
    logic              len_we;
    logic              name_we;
    logic [MAX_PATTERN_BYTES-1:0] row_be;
    logic [RW-1:0]     row_wdata;
    logic [LW-1:0]     len_wdata;
    logic [CW-1:0]     count_next;
    logic              refuse_next;
    logic              pkt_we;
    logic [RW-1:0]     rd_row;
    logic [LW-1:0]     rd_len;
    logic [NAME_W-1:0] rd_name;
    logic              bytes_eq;
    logic              hit;
    logic              exhausted;
    logic [ACTION_W-1:0] mode_action;

    assign op        = opcode_t'(opcode);
    assign wr_addr   = AW'(entry_index);
    assign entry_ok  = 32'(entry_index) < ENTRIES;
    assign pos_ok    = 32'(byte_position) < MAX_PATTERN_BYTES;
    assign row_we    = cmd.accept && (op == OP_PATTERN_BYTE) && entry_ok && pos_ok;
    assign len_we    = cmd.accept && (op == OP_PATTERN_LEN) && entry_ok;
    assign name_we   = cmd.accept && (op == OP_TYPE_NAME) && entry_ok;
    assign len_wdata = (32'(entry_length) > MAX_PATTERN_BYTES) ?
                       LW'(MAX_PATTERN_BYTES) : LW'(entry_length);
    assign count_next  = (32'(count_reg) <= MAX_PACKET_BYTES) ? count_reg + 1'b1 : count_reg;
    assign refuse_next = (mode_reg == MODE_OFF) || (32'(count_next) > MAX_PACKET_BYTES);
    assign pkt_we      = cmd.accept && (op == OP_PACKET) &&
                         (32'(count_reg) < MAX_PATTERN_BYTES);

    // merge a byte into an unwritten row as a full zero row
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            row_be[k] = !row_vld_reg[wr_addr] || (32'(byte_position) == k);
            row_wdata[k*BYTE_W +: BYTE_W] = (32'(byte_position) == k) ? data_byte : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
            begin
                if (row_be[k])
                begin
                    row_mem[wr_addr][k*BYTE_W +: BYTE_W] <= row_wdata[k*BYTE_W +: BYTE_W];
                end
            end
        end
        if (len_we)
        begin
            len_mem[wr_addr] <= len_wdata;
        end
        if (name_we)
        begin
            name_mem[wr_addr] <= type_name & NAME_MASK;
        end
        if (cmd.scan && issue_on_reg)
        begin
            rd_row_raw_reg  <= row_mem[addr_reg];
            rd_len_raw_reg  <= len_mem[addr_reg];
            rd_name_raw_reg <= name_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_we)
        begin
            pkt_buf_reg[PW'(count_reg)] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFF;
            count_reg       <= '0;
            pkt_len_reg     <= '0;
            refuse_reg      <= 1'b0;
            addr_reg        <= '0;
            issue_on_reg    <= 1'b0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            rd_row_vld_reg  <= 1'b0;
            rd_len_vld_reg  <= 1'b0;
            rd_name_vld_reg <= 1'b0;
            row_vld_reg     <= '0;
            len_vld_reg     <= '0;
            name_vld_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.accept)
            begin
                unique case (op)
                    OP_PACKET:
                    begin
                        if (last_byte)
                        begin
                            count_reg    <= '0;
                            pkt_len_reg  <= count_next;
                            refuse_reg   <= refuse_next;
                            addr_reg     <= '0;
                            issue_on_reg <= 1'b1;
                            rd_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_next;
                        end
                    end
                    OP_PATTERN_BYTE:
                    begin
                        if (row_we)
                        begin
                            row_vld_reg[wr_addr] <= 1'b1;
                        end
                    end
                    OP_PATTERN_LEN:
                    begin
                        if (len_we)
                        begin
                            len_vld_reg[wr_addr] <= 1'b1;
                        end
                    end
                    OP_TYPE_NAME:
                    begin
                        if (name_we)
                        begin
                            name_vld_reg[wr_addr] <= 1'b1;
                        end
                    end
                endcase
            end
            if (cmd.scan)
            begin
                rd_valid_reg <= issue_on_reg;
                rd_idx_reg   <= addr_reg;
                if (issue_on_reg)
                begin
                    rd_row_vld_reg  <= row_vld_reg[addr_reg];
                    rd_len_vld_reg  <= len_vld_reg[addr_reg];
                    rd_name_vld_reg <= name_vld_reg[addr_reg];
                    if (addr_reg == LAST_ADDR)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign rd_row  = rd_row_vld_reg  ? rd_row_raw_reg  : '0;
    assign rd_len  = rd_len_vld_reg  ? rd_len_raw_reg  : '0;
    assign rd_name = rd_name_vld_reg ? rd_name_raw_reg : '0;

    always_comb
    begin
        bytes_eq = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            if ((k < 32'(rd_len)) && (rd_row[k*BYTE_W +: BYTE_W] != pkt_buf_reg[k]))
            begin
                bytes_eq = 1'b0;
            end
        end
    end

    assign hit       = rd_valid_reg && (32'(rd_len) == 32'(pkt_len_reg)) && bytes_eq;
    assign exhausted = rd_valid_reg && (rd_idx_reg == LAST_ADDR);

    assign stat.end_pkt = (op == OP_PACKET) && last_byte;
    assign stat.done    = refuse_reg || hit || exhausted;

    always_comb
    begin
        unique case (mode_reg)
            MODE_VIDEO: mode_action = ACT_VIDEO;
            MODE_SCENE: mode_action = ACT_SCENE;
            default:    mode_action = ACT_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (refuse_reg)
            begin
                status_reg <= ST_REFUSED;
                index_reg  <= '0;
                action_reg <= ACT_NONE;
                name_reg   <= '0;
            end
            else if (hit)
            begin
                status_reg <= ST_MATCHED;
                index_reg  <= INDEX_W'(rd_idx_reg);
                action_reg <= mode_action;
                name_reg   <= rd_name;
            end
            else
            begin
                status_reg <= ST_NO_MATCH;
                index_reg  <= '0;
                action_reg <= ACT_NONE;
                name_reg   <= '0;
            end
        end
    end

    assign status        = status_reg;
    assign matched_index = index_reg;
    assign action        = action_reg;
    assign matched_name  = name_reg;

endmodule

// ===== hdl/pctm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pctm_ctrl
// Sequencer for word intake, table scan and result handoff.
// ----------------------------------------------------------------------------
`include "packet_command_table_matcher_top_assert.svh"

module pctm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pctm_pkg::dp_stat_t  stat,
    output pctm_pkg::ctrl_cmd_t cmd
);
    import pctm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.end_pkt)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // hold the result load while the result register is occupied
                if (stat.done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
        endcase
    end

    `PCTM_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg,
        "result word dropped before it was taken")
    `PCTM_ASSERT_NEXT(a_end_starts_scan, clk, rst_n, in_valid && in_ready && stat.end_pkt,
        state_reg == S_SEARCH && !in_ready, "packet end did not start a table scan")
    `PCTM_ASSERT_NEXT(a_load_returns_idle, clk, rst_n, cmd.load_out,
        out_valid_reg && state_reg == S_IDLE, "result load did not present a word")
    `PCTM_ASSERT_SAME(a_no_load_while_full, clk, rst_n, out_valid_reg && !out_ready,
        !cmd.load_out, "result register overwritten while stalled")

endmodule

// ===== hdl/packet_command_table_matcher_top.sv =====
// ----------------------------------------------------------------------------
// packet_command_table_matcher_top
// Command pattern table with packet matching against ENTRIES entries (64 by default).
// ----------------------------------------------------------------------------
// Usage:
//   item   : input words. Opcodes write pattern bytes, lengths and type names,
//            or deliver one packet byte; last_byte closes a packet.
//   result : one word per closed packet: status, index, action, name.
//   cfg_we / cfg_wdata : change_mode register, to be written while idle (not enforced by the block).
// Throughput and scan:
//   Load words and non-final packet bytes are taken one per cycle while idle.
//   A final byte starts a scan that reads one table entry per cycle from the
//   pattern, length and name memories; the match is checked in the cycle
//   after each read. The scan ends at the first matching entry or after the
//   last entry; a refused packet is answered without a scan.
//   No word is taken during the scan.
// Reset:
//   All table entries read as zero until written (per-entry valid bits), the
//   mode is off and the packet count is zero. No clearing pass.
// Stall:
//   A result waits in the output register; the next result waits in the search
//   state if the register is still occupied when that result is found.
// ----------------------------------------------------------------------------
module packet_command_table_matcher_top #(
    parameter int ENTRIES           = pctm_pkg::ENTRIES_DEF,
    parameter int MAX_PATTERN_BYTES = pctm_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int MAX_PACKET_BYTES  = pctm_pkg::MAX_PACKET_BYTES_DEF,
    parameter int NAME_BYTES        = pctm_pkg::NAME_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pctm_in_if.sink                     item,
    pctm_out_if.source                  result,
    input  logic                        cfg_we,
    input  logic [pctm_pkg::MODE_W-1:0] cfg_wdata
);
    import pctm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;
    logic      out_valid;

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

    pctm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pctm_datapath #(
        .ENTRIES           (ENTRIES),
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
        .NAME_BYTES        (NAME_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (item.opcode),
        .entry_index   (item.entry_index),
        .byte_position (item.byte_position),
        .data_byte     (item.data_byte),
        .entry_length  (item.entry_length),
        .type_name     (item.type_name),
        .last_byte     (item.last_byte),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .status        (result.status),
        .matched_index (result.matched_index),
        .action        (result.action),
        .matched_name  (result.matched_name)
    );

endmodule
